### hw/rtl/tilt_level_indicator_unit_macros.svh
// Assertion macros for the tilt level indicator unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef TILT_LEVEL_INDICATOR_UNIT_MACROS_SVH
`define TILT_LEVEL_INDICATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TLI_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TLI_ASSERT_NEVER(name, clk, rst, cond, msg) \
   `TLI_ASSERT(name, clk, rst, !(cond), msg)
`else
`define TLI_ASSERT(name, clk, rst, prop, msg)
`define TLI_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

### hw/rtl/tli_pkg.sv
// Shared constants, codes and struct types for the tilt level indicator unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tli_pkg;

   // sample accumulation
   localparam int MAX_SAMPLES = 32;
   localparam int DATA_W      = 16;
   localparam int SUM_W       = DATA_W + $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int DIV_STEPS   = SUM_W;

   // configuration registers
   localparam int MODE_W     = 2;
   localparam int THRESH_W   = 14;
   localparam int SCALE_W    = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] REG_AXIS_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLAT_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_SPAN  = 2'd2;

   localparam logic [MODE_W-1:0]   AXIS_MODE_RST = 2'd1;
   localparam logic [THRESH_W-1:0] THRESH_RST    = 14'd200;
   localparam logic [SCALE_W-1:0]  SCALE_RST     = 14'd1800;

   // axis mode codes (any other code acts as the X rail)
   localparam logic [MODE_W-1:0] MODE_X  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_Y  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_2D = 2'd2;

   // input kinds
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   // rail layout
   localparam int RAIL_CELLS = 6;
   localparam int HALF_CELLS = 3;
   localparam int CELL_BITS  = 2;
   localparam int RAIL_W     = RAIL_CELLS * CELL_BITS;
   localparam int PHASE_W    = 3;

   localparam logic [CELL_BITS-1:0] CELL_DASH   = 2'd0;
   localparam logic [CELL_BITS-1:0] CELL_DIM    = 2'd1;
   localparam logic [CELL_BITS-1:0] CELL_BRIGHT = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]   axis_mode;
      logic [THRESH_W-1:0] flat_limit;
      logic [SCALE_W-1:0]  edge_span;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accumulate;
      logic div_start;
      logic div_step;
      logic smooth;
      logic prep;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_nz;
   } status_type;

   // result payload, last member in the lowest bits
   typedef struct packed {
      logic signed [DATA_W-1:0] filtered_y;
      logic signed [DATA_W-1:0] filtered_x;
      logic                     beep;
      logic                     indicator_on;
      logic                     led_on;
      logic                     level_ok;
      logic [RAIL_W-1:0]        rail_cells;
   } result_type;

   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int RSP_DATA_W = $bits(result_type);

endpackage

`default_nettype wire

### hw/rtl/tli_divider.sv
// Restoring signed divider: running sum by sample count, one quotient bit per step.
// Depends on tli_pkg for widths.
`default_nettype none

module tli_divider
   import tli_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     start,
   input  wire logic                     step,
   input  wire logic signed [SUM_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]         divisor,
   output logic signed [DATA_W-1:0]      quotient
);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [CNT_W:0]   rem_sh;
   logic             fits;
   logic [DATA_W:0]  mag;
   logic [DATA_W:0]  signed_res;

   // shift in the next dividend bit and try a subtract
   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (start) begin
         neg_in = dividend[SUM_W-1];
         quo_in = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in = '0;
         den_in = divisor;
      end else if (step) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? CNT_W'(rem_sh - {1'b0, den_ff}) : rem_sh[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // restore the sign; the mean always fits the sample width
   assign mag        = (DATA_W+1)'(quo_ff);
   assign signed_res = neg_ff ? (DATA_W+1)'(-mag) : mag;
   assign quotient   = signed_res[DATA_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/tli_datapath.sv
// Datapath: sample sums, two dividers, smoothing, rail drawing and result register.
// Depends on tli_pkg and tli_divider.
`default_nettype none

module tli_datapath
   import tli_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire cfg_type                  cfg,
   input  wire logic signed [DATA_W-1:0] accel_x,
   input  wire logic signed [DATA_W-1:0] accel_y,
   output status_type                    status,
   output result_type                    result
);

   logic signed [SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0]  sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] avg_x_ff, avg_x_in;
   logic signed [DATA_W-1:0] avg_y_ff, avg_y_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [DATA_W:0]          u3_ff, u3_in;
   logic [SCALE_W-1:0]       scale_ff, scale_in;
   result_type               result_ff, result_in;

   logic signed [DATA_W-1:0] mean_x, mean_y;

   function automatic logic signed [DATA_W-1:0] smooth_avg(
      input logic signed [DATA_W-1:0] old,
      input logic signed [DATA_W-1:0] mean
   );
      logic signed [DATA_W+2:0] o;
      logic signed [DATA_W+2:0] acc;
      o   = {{3{old[DATA_W-1]}}, old};
      acc = (o <<< 1) + o + {{3{mean[DATA_W-1]}}, mean};
      // divide by four, truncating toward zero
      if (acc[DATA_W+2]) acc = acc + (DATA_W+3)'(3);
      return acc[DATA_W+1:2];
   endfunction

   function automatic logic axis_is_flat(
      input logic signed [DATA_W-1:0] v,
      input logic [THRESH_W-1:0]      t
   );
      logic signed [DATA_W:0] vv;
      logic signed [DATA_W:0] tt;
      vv = {v[DATA_W-1], v};
      tt = $signed((DATA_W+1)'(t));
      return (vv > -tt) && (vv < tt);
   endfunction

   function automatic logic [1:0] pos3(
      input logic signed [DATA_W-1:0] v,
      input logic [THRESH_W-1:0]      t
   );
      logic signed [DATA_W:0] vv;
      logic signed [DATA_W:0] tt;
      vv = {v[DATA_W-1], v};
      tt = $signed((DATA_W+1)'(t));
      if (vv < -tt)     return 2'd0;
      else if (vv > tt) return 2'd2;
      else              return 2'd1;
   endfunction

   function automatic logic [CELL_BITS-1:0] cell_code(input logic bright);
      return bright ? CELL_BRIGHT : CELL_DIM;
   endfunction

   // accumulate samples; count saturates and further samples drop
   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      count_in = count_ff;
      if (cmd.smooth) begin
         sum_x_in = '0;
         sum_y_in = '0;
         count_in = '0;
      end else if (cmd.accumulate && (count_ff < CNT_W'(MAX_SAMPLES))) begin
         sum_x_in = sum_x_ff + SUM_W'(accel_x);
         sum_y_in = sum_y_ff + SUM_W'(accel_y);
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign status.count_nz = (count_ff != '0);

   tli_divider u_div_x (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_x_ff),
      .divisor  (count_ff),
      .quotient (mean_x)
   );

   tli_divider u_div_y (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_y_ff),
      .divisor  (count_ff),
      .quotient (mean_y)
   );

   // exponential average
   assign avg_x_in = cmd.smooth ? smooth_avg(avg_x_ff, mean_x) : avg_x_ff;
   assign avg_y_in = cmd.smooth ? smooth_avg(avg_y_ff, mean_y) : avg_y_ff;

   // rail prep: clamp the selected reading, offset by scale, times three
   always_comb begin
      logic [SCALE_W-1:0]       s;
      logic signed [DATA_W-1:0] sel;
      logic signed [DATA_W:0]   c;
      logic signed [DATA_W:0]   s17;
      logic [DATA_W:0]          u;
      s        = (cfg.edge_span == '0) ? SCALE_W'(1) : cfg.edge_span;
      sel      = (cfg.axis_mode == MODE_Y) ? avg_y_ff : avg_x_ff;
      s17      = $signed((DATA_W+1)'(s));
      c        = {sel[DATA_W-1], sel};
      if (c < -s17) c = -s17;
      if (c > s17)  c = s17;
      u        = $unsigned(c + s17);
      u3_in    = cmd.prep ? (DATA_W+1)'((u << 1) + u) : u3_ff;
      scale_in = cmd.prep ? s : scale_ff;
   end

   // rail drawing and flags
   always_comb begin
      logic [DATA_W:0]   ks1, ks2, ks3, ks4, ks5;
      logic [2:0]        p6;
      logic [1:0]        xp, yp;
      logic              flash, xl, yl, lv, both;
      logic [RAIL_W-1:0] cells;
      // rail position is floor(3u / scale) capped at 5, counted against multiples of scale
      ks1   = (DATA_W+1)'(scale_ff);
      ks2   = ks1 << 1;
      ks3   = ks1 + ks2;
      ks4   = ks1 << 2;
      ks5   = ks1 + ks4;
      p6    = 3'(u3_ff >= ks1) + 3'(u3_ff >= ks2) + 3'(u3_ff >= ks3)
            + 3'(u3_ff >= ks4) + 3'(u3_ff >= ks5);
      flash = ~phase_ff[1];
      xl    = axis_is_flat(avg_x_ff, cfg.flat_limit);
      yl    = axis_is_flat(avg_y_ff, cfg.flat_limit);
      xp    = pos3(avg_x_ff, cfg.flat_limit);
      yp    = pos3(avg_y_ff, cfg.flat_limit);
      lv    = (cfg.axis_mode == MODE_Y) ? yl : xl;
      cells = '0;
      if (cfg.axis_mode == MODE_2D) begin
         cells[{yp, 1'b0} +: CELL_BITS] = cell_code(yl && flash);
         cells[4'(HALF_CELLS * CELL_BITS) + {1'b0, xp, 1'b0} +: CELL_BITS] =
            cell_code(xl && flash);
         both = xl && yl;
      end else begin
         cells[{p6, 1'b0} +: CELL_BITS] = cell_code(lv && flash);
         both = lv;
      end
      result_in = result_ff;
      if (cmd.load_out) begin
         result_in.rail_cells   = cells;
         result_in.level_ok     = both;
         result_in.led_on       = both;
         result_in.indicator_on = both && flash;
         result_in.beep         = both && (phase_ff == '0);
         result_in.filtered_x   = avg_x_ff;
         result_in.filtered_y   = avg_y_ff;
      end
   end

   assign phase_in = cmd.load_out ? phase_ff + PHASE_W'(1) : phase_ff;

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         count_ff <= '0;
         avg_x_ff <= '0;
         avg_y_ff <= '0;
         phase_ff <= '0;
      end else begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         count_ff <= count_in;
         avg_x_ff <= avg_x_in;
         avg_y_ff <= avg_y_in;
         phase_ff <= phase_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      u3_ff     <= u3_in;
      scale_ff  <= scale_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### hw/rtl/tli_ctrl.sv
// Controller: input acceptance, divide sequencing, result valid handling.
// Depends on tli_pkg and tilt_level_indicator_unit_macros.svh.
`default_nettype none
`include "tilt_level_indicator_unit_macros.svh"

module tli_ctrl
   import tli_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_tuser,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVIDE = 3'd1;
   localparam logic [2:0] ST_SMOOTH = 3'd2;
   localparam logic [2:0] ST_PREP   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // sequencing
   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == ACT_SAMPLE) begin
                  cmd.accumulate = 1'b1;
               end else if (status.count_nz) begin
                  cmd.div_start = 1'b1;
                  step_cnt_in   = '0;
                  state_in      = ST_DIVIDE;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_SMOOTH;
            end else begin
               step_cnt_in = step_cnt_ff + STEP_W'(1);
            end
         end
         ST_SMOOTH: begin
            cmd.smooth = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `TLI_ASSERT(a_div_needs_samples, clock, reset, (state_ff == ST_DIVIDE && $past(state_ff) == ST_IDLE) |-> $past(status.count_nz), "divide started with no samples")
   `TLI_ASSERT_NEVER(a_step_bound, clock, reset, state_ff == ST_DIVIDE && step_cnt_ff >= STEP_W'(DIV_STEPS), "divide step count overran")
   `TLI_ASSERT(a_valid_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT), "result valid raised outside emit")
   `TLI_ASSERT(a_tick_leaves_idle, clock, reset, (accept && req_tuser == ACT_TICK) |=> (state_ff != ST_IDLE), "tick transfer did not start processing")

endmodule

`default_nettype wire

### hw/rtl/tilt_level_indicator_unit.sv
// Tilt level indicator: bubble-level rail from averaged accelerometer samples.
//
// Input channel (req_): one transfer per item. req_tuser = 0 is a sample
// (req_tdata carries accel_x and accel_y), req_tuser = 1 is a display tick.
// Samples add into running sums and give no result; after 32
// samples further ones are dropped until the next tick.
// Each tick gives exactly one result transfer on rsp_ (rail, flags, smoothed
// readings). With samples pending, a tick passes through the shift-subtract
// divider (one quotient bit per cycle, both axes in parallel), a smoothing
// state, a rail prep state and the output register load before rsp_tvalid.
// With no samples pending it skips the divider and the smoothing state.
// The block takes no item while a tick is in flight; samples are accepted
// while a result waits in the output register. When rsp_tready is low, a
// finished tick waits in its last state until the register frees up.
// csr_ writes land at the clock edge with csr_wr_en high; write them only
// while the block is idle. Synchronous reset clears sums, averages, tick phase
// and valid, and loads axis mode 1, flat limit 200 and edge span 1800.
// Depends on tli_pkg, tli_ctrl, tli_datapath, tli_divider.
`default_nettype none

module tilt_level_indicator_unit
   import tli_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // accel_x, accel_y
   input  wire logic                  req_tuser,  // action
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rail_cells, level_ok, led_on, indicator_on, beep, filtered_x, filtered_y
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   result_type result;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_AXIS_MODE:  cfg_in.axis_mode  = csr_wdata[MODE_W-1:0];
            REG_FLAT_LIMIT: cfg_in.flat_limit = csr_wdata[THRESH_W-1:0];
            REG_EDGE_SPAN:  cfg_in.edge_span  = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_mode  <= AXIS_MODE_RST;
         cfg_ff.flat_limit <= THRESH_RST;
         cfg_ff.edge_span  <= SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tli_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .cfg     (cfg_ff),
      .accel_x (req_tdata[DATA_W-1:0]),
      .accel_y (req_tdata[2*DATA_W-1:DATA_W]),
      .status  (status),
      .result  (result)
   );

   assign rsp_tdata = result;

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for tilt_level_indicator_unit: directed stimulus table,
// then random sample bursts and ticks across register settings, against a predictor or typed table rows.
// Depends on tli_pkg and the RTL of tilt_level_indicator_unit.

module tb_top;
   import tli_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 40;     // margin past a tick's processing
   localparam int HOLD_CYCLES  = 400;    // receiver back-pressure stretch
   localparam int TOTAL_ITEMS  = 1050;
   localparam int REG_MAX      = (1 << THRESH_W) - 1;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused code, acts as X rail

   // one row of the directed table
   typedef struct packed {
      logic                     act;
      logic signed [DATA_W-1:0] ax;
      logic signed [DATA_W-1:0] ay;
      logic [5:0]               reps;
      logic                     typed;
      result_type               want;
   } drive_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // accel_x, accel_y
   logic                  req_tuser  = 1'b0; // action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // rail_cells, level_ok, led_on, indicator_on, beep, filtered_x, filtered_y
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor state and its copy of the registers
   int                est_avg_x, est_avg_y, acc_sum_x, acc_sum_y, acc_count, tick_ph;
   logic [MODE_W-1:0] cfg_mode   = AXIS_MODE_RST;
   int                cfg_thresh = THRESH_RST;
   int                cfg_scale  = SCALE_RST;

   result_type pending_readouts[$];
   result_type typed_rsp   = '0;
   bit         typed_armed = 1'b0;
   bit         gaps_on     = 1'b1;
   bit         hold_armed  = 1'b0;
   bit         hold_done   = 1'b0;
   int         fail_count  = 0;
   int         items_sent  = 0;

   drive_row_type dir_rows [17] = '{
      // level at rest, reset registers: Y rail, bubble bright in cell 3, beep on phase 0
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b1,
        '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b1, 12'h080}},
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b1,
        '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b1, 12'h080}},
      // flash phase off: dim bubble, indicator dark
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b1,
        '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b1, 12'h040}},
      // extreme readings
      '{ACT_SAMPLE, 16'sh7FFF, 16'sh8000, 6'd1, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b1,
        '{-16'sd8192, 16'sd8191, 1'b0, 1'b0, 1'b0, 1'b0, 12'h001}},
      '{ACT_SAMPLE, 16'sh8000, 16'sh7FFF, 6'd1, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b0, '0},
      // count saturates, extra samples dropped
      '{ACT_SAMPLE, 16'sd1000, -16'sd1000, 6'd40, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b0, '0},
      // sums at their negative and positive extremes
      '{ACT_SAMPLE, 16'sh8000, 16'sh8000, 6'd33, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b0, '0},
      '{ACT_SAMPLE, 16'sh7FFF, 16'sh7FFF, 6'd32, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 6'd1, 1'b0, '0},
      // mean truncates toward zero
      '{ACT_SAMPLE, -16'sd3, 16'sd5, 6'd1, 1'b0, '0},
      '{ACT_SAMPLE, -16'sd2, 16'sd4, 6'd1, 1'b0, '0},
      '{ACT_TICK, 16'sh7FFF, 16'sh8000, 6'd1, 1'b0, '0},
      // no samples: averages hold, data ignored
      '{ACT_TICK, -16'sd1, -16'sd1, 6'd1, 1'b0, '0}
   };

   cfg_type sweep_cfgs [8] = '{
      '{MODE_X,     14'd200,   14'd1800},
      '{MODE_2D,    14'd200,   14'd1800},
      '{MODE_SPARE, 14'd1,     14'd1},
      '{MODE_2D,    14'd16383, 14'd16383},
      '{MODE_Y,     14'd0,     14'd0},
      '{MODE_X,     14'd16383, 14'd1},
      '{MODE_2D,    14'd0,     14'd5},
      '{MODE_Y,     14'd1,     14'd16383}
   };

   tilt_level_indicator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   function automatic bit axis_level(input int v);
      return v > -cfg_thresh && v < cfg_thresh;
   endfunction

   function automatic int half_rail_pos(input int v);
      if (v < -cfg_thresh) return 0;
      if (v > cfg_thresh) return 2;
      return 1;
   endfunction

   function automatic void level_step(input logic act, input logic signed [DATA_W-1:0] ax,
                                      input logic signed [DATA_W-1:0] ay,
                                      output bit made, output result_type r);
      int                s, c, pos;
      bit                flash, xl, yl, lv, both, use_y;
      logic [RAIL_W-1:0] cells;
      made = 1'b0;
      r    = '0;
      if (act == ACT_SAMPLE) begin
         if (acc_count < MAX_SAMPLES) begin
            acc_sum_x += ax;
            acc_sum_y += ay;
            acc_count++;
         end
         return;
      end
      // fold the window mean into the running average
      if (acc_count > 0) begin
         est_avg_x = (est_avg_x * 3 + acc_sum_x / acc_count) / 4;
         est_avg_y = (est_avg_y * 3 + acc_sum_y / acc_count) / 4;
         acc_sum_x = 0;
         acc_sum_y = 0;
         acc_count = 0;
      end
      flash = (tick_ph % 4) < 2;
      xl    = axis_level(est_avg_x);
      yl    = axis_level(est_avg_y);
      if (cfg_mode == MODE_2D) begin
         // cells 0..2 show Y, 3..5 show X
         cells = (RAIL_W'((yl && flash) ? CELL_BRIGHT : CELL_DIM)
                  << (CELL_BITS * half_rail_pos(est_avg_y)))
               | (RAIL_W'((xl && flash) ? CELL_BRIGHT : CELL_DIM)
                  << (CELL_BITS * (HALF_CELLS + half_rail_pos(est_avg_x))));
         both  = xl && yl;
      end else begin
         use_y = cfg_mode == MODE_Y;
         c     = use_y ? est_avg_y : est_avg_x;
         lv    = use_y ? yl : xl;
         s     = (cfg_scale == 0) ? 1 : cfg_scale;
         if (c < -s) c = -s;
         if (c > s) c = s;
         pos = (c + s) * RAIL_CELLS / (2 * s);
         if (pos > RAIL_CELLS - 1) pos = RAIL_CELLS - 1;
         cells = RAIL_W'((lv && flash) ? CELL_BRIGHT : CELL_DIM) << (CELL_BITS * pos);
         both  = lv;
      end
      r.rail_cells   = cells;
      r.level_ok     = both;
      r.led_on       = both;
      r.indicator_on = both && flash;
      r.beep         = both && tick_ph == 0;
      r.filtered_x   = DATA_W'(est_avg_x);
      r.filtered_y   = DATA_W'(est_avg_y);
      made           = 1'b1;
      tick_ph        = (tick_ph + 1) % (1 << PHASE_W);
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: results checked against the oldest expectation, inputs predicted
   // ---------------------------------------------------------------------------
   task automatic check_field(input string name, input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type got, want;
      bit         made;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata);
         if (pending_readouts.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_readouts.pop_front();
            check_field("rail_cells", want.rail_cells, got.rail_cells);
            check_field("level_ok", want.level_ok, got.level_ok);
            check_field("led_on", want.led_on, got.led_on);
            check_field("indicator_on", want.indicator_on, got.indicator_on);
            check_field("beep", want.beep, got.beep);
            check_field("filtered_x", want.filtered_x, got.filtered_x);
            check_field("filtered_y", want.filtered_y, got.filtered_y);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         level_step(req_tuser, req_tdata[DATA_W-1:0], req_tdata[2*DATA_W-1:DATA_W], made, want);
         if (made) pending_readouts.push_back(typed_armed ? typed_rsp : want);
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off when armed
   // ---------------------------------------------------------------------------
   always begin
      @(negedge clock);
      if (hold_armed && !hold_done) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_done = 1'b1;
      end
      rsp_tready <= !gaps_on || ($urandom_range(99) >= 30);
   end

   // ---------------------------------------------------------------------------
   // Sender tasks, entered and left at a falling edge
   // ---------------------------------------------------------------------------
   task automatic send_item(input logic act, input logic signed [DATA_W-1:0] ax,
                            input logic signed [DATA_W-1:0] ay);
      if (gaps_on && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (gaps_on && $urandom_range(99) < 30);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // wait until every expected result is in and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(input cfg_type c);
      csr_wr_en <= 1'b1;
      csr_index <= REG_AXIS_MODE;
      csr_wdata <= CSR_DATA_W'(c.axis_mode);
      @(negedge clock);
      csr_index <= REG_FLAT_LIMIT;
      csr_wdata <= c.flat_limit;
      @(negedge clock);
      csr_index <= REG_EDGE_SPAN;
      csr_wdata <= c.edge_span;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      cfg_mode   = c.axis_mode;
      cfg_thresh = c.flat_limit;
      cfg_scale  = c.edge_span;
   endtask

   function automatic logic [THRESH_W-1:0] pick_reg();
      unique case ($urandom_range(9))
         0:       return '0;
         1:       return REG_MAX;
         2, 3:    return THRESH_W'($urandom_range(50, 1));
         4, 5, 6: return THRESH_W'($urandom_range(2000, 51));
         default: return THRESH_W'($urandom_range(REG_MAX, 1));
      endcase
   endfunction

   // bursts of samples around a slowly moving target, each closed by a tick;
   // some lone ticks, overfull bursts and fully random readings mixed in
   task automatic run_traffic(input int n_items);
      int done_n, sel, burst, k, tx, ty, span;
      bit wild;
      done_n = 0;
      tx     = 0;
      ty     = 0;
      wild   = 1'b0;
      while (done_n < n_items && items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(99) < 40) begin
            sel  = $urandom_range(99);
            wild = sel >= 75;
            span = (sel < 45) ? 400 : cfg_scale + cfg_scale / 4 + 1;
            tx   = int'($urandom_range(2 * span)) - span;
            ty   = int'($urandom_range(2 * span)) - span;
         end
         sel   = $urandom_range(99);
         burst = (sel < 8) ? 0 : (sel < 14) ? $urandom_range(40, 33) : $urandom_range(12, 1);
         for (k = 0; k < burst; k++) begin
            if (wild)
               send_item(ACT_SAMPLE, DATA_W'($urandom), DATA_W'($urandom));
            else
               send_item(ACT_SAMPLE, DATA_W'(tx + int'($urandom_range(40)) - 20),
                         DATA_W'(ty + int'($urandom_range(40)) - 20));
         end
         send_item(ACT_TICK, DATA_W'($urandom), DATA_W'($urandom));
         done_n += burst + 1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int      p, thr;
      cfg_type c;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed table with reset register values
      foreach (dir_rows[i]) begin
         typed_armed = dir_rows[i].typed;
         typed_rsp   = dir_rows[i].want;
         repeat (dir_rows[i].reps) send_item(dir_rows[i].act, dir_rows[i].ax, dir_rows[i].ay);
      end
      typed_armed = 1'b0;
      settle();

      // 2D rail with the Y reading sitting exactly on the threshold
      thr = (est_avg_y < 0) ? -est_avg_y : est_avg_y;
      if (thr == 0) thr = 1;
      if (thr > REG_MAX) thr = REG_MAX;
      write_config('{MODE_2D, THRESH_W'(thr), SCALE_RST});
      send_item(ACT_TICK, '0, '0);
      settle();

      // register sweep with extremes, then random settings
      p = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (p < 8) c = sweep_cfgs[p];
         else c = '{MODE_W'($urandom_range(3)), pick_reg(), pick_reg()};
         if (p == 9) hold_armed = 1'b1;
         gaps_on = (p != 10);
         write_config(c);
         run_traffic((p < 8) ? 40 : 140);
         settle();
         p++;
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tli_pkg.sv
hw/rtl/tli_divider.sv
hw/rtl/tli_datapath.sv
hw/rtl/tli_ctrl.sv
hw/rtl/tilt_level_indicator_unit.sv
sim/tb_top.sv
